>>> rtl/core/nmr_pkg.sv
// ----------------------------------------------------------------------------
// nmr_pkg
// Types and constants shared by the normal-map renormalizer pipeline.
// ----------------------------------------------------------------------------
package nmr_pkg;

   // bits of the magnitude search, one pipeline stage each
   localparam int unsigned STEP_COUNT = 7;
   // cycles from an accepted start to the result strobe
   localparam int unsigned LATENCY = STEP_COUNT + 4;
   // 255 * 255
   localparam logic [31:0] SCALE_SQ = 32'd65025;

   typedef struct packed {
      logic        neg;    // component is negative
      logic [31:0] a;      // (255*|d|)^2
      logic [34:0] p;      // 4*m^2*S for the bits found so far
      logic [26:0] q;      // 4*m*S
      logic [6:0]  m;      // floor(|t|), built MSB first
   } chan_type;

   typedef struct packed {
      logic                valid;
      logic                en;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [7:0]          alpha;
      logic [19:0]         s4;     // 4*S
      chan_type [2:0]      chan;
   } stage_type;

endpackage

>>> rtl/core/nmr_step.sv
// ----------------------------------------------------------------------------
// nmr_step
// One stage of the magnitude search: tries one bit of m on all three
// channels with shift-and-add updates of 4*m^2*S and 4*m*S.
// ----------------------------------------------------------------------------
module nmr_step
   import nmr_pkg::*;
#(
   parameter int unsigned BIT_POS = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in,
   output stage_type stage_out
);

   stage_type stage_in_c;
   stage_type stage_ff;

   always_comb begin
      logic [34:0] cand;
      stage_in_c = stage_in;
      for (int c = 0; c < 3; c++) begin
         // (m + 2^j)^2 = m^2 + 2^(j+1)*m + 2^(2j)
         cand = stage_in.chan[c].p
              + (35'(stage_in.chan[c].q) << (BIT_POS + 1))
              + (35'(stage_in.s4) << (2 * BIT_POS));
         if (cand <= 35'(stage_in.chan[c].a)) begin
            stage_in_c.chan[c].p          = cand;
            stage_in_c.chan[c].q          = stage_in.chan[c].q
                                          + (27'(stage_in.s4) << BIT_POS);
            stage_in_c.chan[c].m[BIT_POS] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> rtl/core/normal_map_pixel_renormalize.sv
// ----------------------------------------------------------------------------
// normal_map_pixel_renormalize
// Rescales the RGB vector of an RGBA8 normal-map pixel to unit length, or passes it through when disabled.
// ----------------------------------------------------------------------------
// Fully pipelined: a pixel may start in every cycle and busy never rises.
// Each result appears on the rsp_ ports, marked by rsp_valid, once its
// start transfer has passed the input register, squaring, sum and scale,
// seven search stages (one bit of the 7-bit magnitude each) and the output
// register. The receiver cannot stall; results are in start order.
// csr_write_en is only to be used while the pipeline is empty; each pixel
// keeps the enable it saw on entry.
module normal_map_pixel_renormalize
   import nmr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_alpha_in,
   output logic       rsp_valid,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_alpha_out
);

   logic       enable_ff;

   // stage 1: input register
   logic       s1_valid_ff;
   logic       s1_en_ff;
   logic [7:0] s1_pix_ff [4];

   // stage 2: squared magnitudes
   logic       s2_valid_ff;
   logic       s2_en_ff;
   logic [7:0] s2_pix_ff [4];
   logic [2:0] s2_neg_ff;
   logic [15:0] s2_sq_ff [3];

   logic [7:0] mag_c [3];
   logic [17:0] sum_c;

   stage_type  s3_in;
   stage_type  s3_ff;
   stage_type  step_data [STEP_COUNT + 1];

   logic       out_valid_ff;
   logic [7:0] out_pix_ff [4];
   logic [7:0] out_pix_in [4];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_write_en) begin
         enable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      s1_en_ff     <= enable_ff;
      s1_pix_ff[0] <= req_red_in;
      s1_pix_ff[1] <= req_green_in;
      s1_pix_ff[2] <= req_blue_in;
      s1_pix_ff[3] <= req_alpha_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   // |2p - 255| is {p[6:0],1} above mid-scale, {~p[6:0],1} below
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_c[c] = s1_pix_ff[c][7] ? {s1_pix_ff[c][6:0], 1'b1}
                                    : {~s1_pix_ff[c][6:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      s2_en_ff  <= s1_en_ff;
      s2_pix_ff <= s1_pix_ff;
      for (int c = 0; c < 3; c++) begin
         s2_neg_ff[c] <= ~s1_pix_ff[c][7];
         s2_sq_ff[c]  <= 16'(mag_c[c]) * 16'(mag_c[c]);
      end
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign sum_c = 18'(s2_sq_ff[0]) + 18'(s2_sq_ff[1]) + 18'(s2_sq_ff[2]);

   always_comb begin
      s3_in.valid = s2_valid_ff;
      s3_in.en    = s2_en_ff;
      s3_in.red   = s2_pix_ff[0];
      s3_in.green = s2_pix_ff[1];
      s3_in.blue  = s2_pix_ff[2];
      s3_in.alpha = s2_pix_ff[3];
      s3_in.s4    = {sum_c, 2'b00};
      for (int c = 0; c < 3; c++) begin
         s3_in.chan[c].neg = s2_neg_ff[c];
         s3_in.chan[c].a   = 32'(s2_sq_ff[c]) * SCALE_SQ;
         s3_in.chan[c].p   = '0;
         s3_in.chan[c].q   = '0;
         s3_in.chan[c].m   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
      end else begin
         s3_ff <= s3_in;
      end
   end

   assign step_data[0] = s3_ff;

   for (genvar g = 0; g < STEP_COUNT; g++) begin : g_step
      nmr_step #(
         .BIT_POS (STEP_COUNT - 1 - g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (step_data[g]),
         .stage_out (step_data[g + 1])
      );
   end

   // positive: 128 + m; negative: 127 - m, plus one when m is exact
   always_comb begin
      stage_type   fin;
      logic        exact;
      fin = step_data[STEP_COUNT];
      for (int c = 0; c < 3; c++) begin
         exact = (fin.chan[c].p == 35'(fin.chan[c].a));
         if (fin.chan[c].neg) begin
            out_pix_in[c] = {1'b0, ~fin.chan[c].m} + 8'(exact);
         end else begin
            out_pix_in[c] = {1'b1, fin.chan[c].m};
         end
      end
      if (!fin.en) begin
         out_pix_in[0] = fin.red;
         out_pix_in[1] = fin.green;
         out_pix_in[2] = fin.blue;
      end
      out_pix_in[3] = fin.alpha;
   end

   always_ff @(posedge clock) begin
      out_pix_ff <= out_pix_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= step_data[STEP_COUNT].valid;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_pix_ff[0];
   assign rsp_green_out = out_pix_ff[1];
   assign rsp_blue_out  = out_pix_ff[2];
   assign rsp_alpha_out = out_pix_ff[3];

   // every start transfer gives exactly one result
   a_start_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_valid)
      else $error("start transfer produced no result");

   a_rsp_has_start : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 11))
      else $error("result without a matching start transfer");

   a_alpha_carried : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha_out == $past(req_alpha_in, 11)))
      else $error("alpha not carried with its pixel");

endmodule
